// ===== hdl/zlhd_pkg.sv =====
// shared types, register codes and level clamp helpers for the zoom level hold block
`timescale 1ns / 1ps

package zlhd_pkg;

    localparam int LVL_W  = 4;
    localparam int HOLD_W = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] REG_MIN_LEVEL      = 2'd0;
    localparam logic [1:0] REG_MAX_LEVEL      = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS     = 2'd2;
    localparam logic [1:0] REG_CONTENT_LOADED = 2'd3;

    localparam logic [LVL_W-1:0]  RST_MIN_LEVEL  = 4'd0;
    localparam logic [LVL_W-1:0]  RST_MAX_LEVEL  = 4'd15;
    localparam logic [HOLD_W-1:0] RST_HOLD_TICKS = 16'd10;
    localparam logic              RST_CONTENT    = 1'b0;

    typedef struct packed {
        logic [LVL_W-1:0]  min_level;
        logic [LVL_W-1:0]  max_level;
        logic [HOLD_W-1:0] hold_ticks;
        logic              content_loaded;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [LVL_W-1:0] wanted_level;
        logic             cache_has_success;
        logic             view_settled;
    } item_t;

    typedef struct packed {
        logic [LVL_W-1:0] held_level;
        logic             holding;
        logic             reached;
        logic             climbed;
    } result_t;

    function automatic logic [LVL_W-1:0] floor_lvl(input logic [LVL_W-1:0] mn, input int top);
        return (int'(mn) > top) ? LVL_W'(top) : mn;
    endfunction

    function automatic logic [LVL_W-1:0] ceil_lvl(input logic [LVL_W-1:0] mn,
                                                 input logic [LVL_W-1:0] mx, input int top);
        logic [LVL_W-1:0] f;
        logic [LVL_W-1:0] c;
        f = floor_lvl(mn, top);
        c = (int'(mx) > top) ? LVL_W'(top) : mx;
        return (c < f) ? f : c;
    endfunction

endpackage

// ===== hdl/zlhd_cfg.sv =====
// apb register file for level range, hold time and content flag
`timescale 1ns / 1ps

module zlhd_cfg
    import zlhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg,
    output cfg_t              cfg_next,
    output logic              restart
);

    cfg_t       cfg_reg;
    logic [1:0] idx;

    assign idx     = paddr[ADDR_W-1:2];
    assign restart = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (restart)
        begin
            case (idx)
                REG_MIN_LEVEL:      cfg_next.min_level      = pwdata[LVL_W-1:0];
                REG_MAX_LEVEL:      cfg_next.max_level      = pwdata[LVL_W-1:0];
                REG_HOLD_TICKS:     cfg_next.hold_ticks     = pwdata[HOLD_W-1:0];
                REG_CONTENT_LOADED: cfg_next.content_loaded = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN_LEVEL:      prdata = DATA_W'(cfg_reg.min_level);
            REG_MAX_LEVEL:      prdata = DATA_W'(cfg_reg.max_level);
            REG_HOLD_TICKS:     prdata = DATA_W'(cfg_reg.hold_ticks);
            REG_CONTENT_LOADED: prdata = DATA_W'(cfg_reg.content_loaded);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_level      <= RST_MIN_LEVEL;
            cfg_reg.max_level      <= RST_MAX_LEVEL;
            cfg_reg.hold_ticks     <= RST_HOLD_TICKS;
            cfg_reg.content_loaded <= RST_CONTENT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/zlhd_core.sv =====
// level hold state registers and the per-item update logic
`timescale 1ns / 1ps

module zlhd_core
    import zlhd_pkg::*;
#(
    parameter int LEVEL_COUNT = 16,
    parameter int TIMER_BITS  = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  cfg_t    cfg_next,
    input  logic    restart,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    localparam int TopLevel = LEVEL_COUNT - 1;
    localparam int CmpW     = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

    logic [LVL_W-1:0]      held_reg, held_next;
    logic [LVL_W-1:0]      desired_reg, desired_next;
    logic [LVL_W-1:0]      pending_reg, pending_next;
    logic                  started_reg, started_next;
    logic                  arrived_reg, arrived_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  climbed;

    logic [LVL_W-1:0] lo, hi, d, step_down;
    logic             timer_done;

    assign lo         = floor_lvl(cfg.min_level, TopLevel);
    assign hi         = ceil_lvl(cfg.min_level, cfg.max_level, TopLevel);
    assign timer_done = CmpW'(timer_reg) >= CmpW'(cfg.hold_ticks);
    assign step_down  = held_reg - LVL_W'(1);

    always_comb
    begin
        d = item.wanted_level;
        if (d < lo)
            d = lo;
        if (d > hi)
            d = hi;
    end

    always_comb
    begin
        held_next    = held_reg;
        desired_next = desired_reg;
        pending_next = pending_reg;
        started_next = started_reg;
        arrived_next = arrived_reg;
        timer_next   = timer_reg;
        climbed      = 1'b0;
        case (item.opcode)
            OP_REQUEST:
            begin
                desired_next = d;
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    pending_next = d;
                    timer_next   = '0;
                    if (!item.cache_has_success && hi > d)
                    begin
                        held_next    = d + LVL_W'(1);
                        arrived_next = 1'b0;
                    end
                    else
                    begin
                        held_next    = d;
                        arrived_next = 1'b1;
                    end
                end
                else if (d > held_reg || (held_reg - d) > LVL_W'(1) && arrived_reg)
                begin
                    // zoom-out, or a settled jump of two or more levels finer
                    held_next    = d;
                    arrived_next = 1'b1;
                    pending_next = d;
                    timer_next   = '0;
                end
                else if (!arrived_reg && held_reg > d)
                begin
                    // cold climb: one level finer per settled view
                    pending_next = d;
                    if (item.view_settled)
                    begin
                        timer_next = '0;
                        if (step_down <= d)
                        begin
                            held_next    = d;
                            arrived_next = 1'b1;
                        end
                        else
                        begin
                            held_next = step_down;
                        end
                    end
                end
                else if (d == held_reg)
                begin
                    arrived_next = 1'b1;
                    pending_next = d;
                end
                else if (d != pending_reg)
                begin
                    pending_next = d;
                    timer_next   = '0;
                end
                else if (timer_done)
                begin
                    held_next    = d;
                    arrived_next = 1'b1;
                end
            end
            OP_ADVANCE:
            begin
                if (started_reg && cfg.content_loaded && !arrived_reg
                    && held_reg > desired_reg && item.view_settled)
                begin
                    climbed = 1'b1;
                    if (step_down <= desired_reg)
                    begin
                        held_next    = desired_reg;
                        arrived_next = 1'b1;
                    end
                    else
                    begin
                        held_next = step_down;
                    end
                end
            end
            OP_TICK:
            begin
                if (!(&timer_reg))
                    timer_next = timer_reg + TIMER_BITS'(1);
            end
            default:
            begin
                climbed = 1'b0;
            end
        endcase
    end

    assign result.held_level = held_next;
    assign result.holding    = started_next && (desired_next != held_next);
    assign result.reached    = arrived_next;
    assign result.climbed    = climbed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            desired_reg <= ceil_lvl(RST_MIN_LEVEL, RST_MAX_LEVEL, TopLevel);
            pending_reg <= '0;
            started_reg <= 1'b0;
            arrived_reg <= 1'b0;
            timer_reg   <= '0;
        end
        else if (restart)
        begin
            held_reg    <= '0;
            desired_reg <= ceil_lvl(cfg_next.min_level, cfg_next.max_level, TopLevel);
            pending_reg <= '0;
            started_reg <= 1'b0;
            arrived_reg <= 1'b0;
            timer_reg   <= '0;
        end
        else if (step)
        begin
            held_reg    <= held_next;
            desired_reg <= desired_next;
            pending_reg <= pending_next;
            started_reg <= started_next;
            arrived_reg <= arrived_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

// ===== hdl/zoom_level_hold_debounce.sv =====
// top level: input register, level hold update and result register
`timescale 1ns / 1ps
// an input transfer is captured in the input register, and its result in the result register
// that drives m_tdata; one item per cycle, every opcode alike, while the sink takes results;
// the state update is combinational compare and clamp logic between the input and result registers
// reset: rst_n clears both stages and the level state at once; a register
// write restarts the level state the same way on the clock edge of the write

module zoom_level_hold_debounce
    import zlhd_pkg::*;
#(
    parameter int LEVEL_COUNT = 16,
    parameter int TIMER_BITS  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,  // wanted_level[3:0], cache_has_success[4], view_settled[5]
    input  logic [1:0]        s_tuser,  // opcode[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata   // held_level[3:0], holding[4], reached[5], climbed[6]
);

    cfg_t    cfg, cfg_next;
    logic    restart;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    logic    out_valid_reg;
    result_t result;
    logic    step;

    assign pready   = 1'b1;
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.climbed, out_res_reg.reached,
                       out_res_reg.holding, out_res_reg.held_level};

    zlhd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .cfg_next (cfg_next),
        .restart  (restart)
    );

    zlhd_core #(
        .LEVEL_COUNT (LEVEL_COUNT),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_next (cfg_next),
        .restart  (restart),
        .step     (step),
        .item     (in_item_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.opcode            <= s_tuser;
            in_item_reg.wanted_level      <= s_tdata[3:0];
            in_item_reg.cache_has_success <= s_tdata[4];
            in_item_reg.view_settled      <= s_tdata[5];
        end
        if (step)
            out_res_reg <= result;
    end

endmodule

// ===== hdl/zlhd_checker.sv =====
// port-level checks for the zoom level hold block and their bind
`timescale 1ns / 1ps

module zlhd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a result waiting for the sink keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the pad bit of a result is always zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7])
        else $error("pad bit set");

    // every input transfer is followed by a valid result on m_tvalid
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing after input transfer");

endmodule

bind zoom_level_hold_debounce zlhd_checker u_zlhd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
